FILE: hdl/ppp_pkg.sv
// shared types and constants for the perspective point projector
package ppp_pkg;

  localparam int unsigned CoordBitsDef  = 16;
  localparam int unsigned ScreenBitsDef = 12;
  localparam int unsigned CfgBits       = 16;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned WhBits        = 13;
  localparam int unsigned DistBits      = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DIST   = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

endpackage

FILE: hdl/ppp_div_cell.sv
// one restoring-division cell: retires one quotient bit of both quotients per cycle
module ppp_div_cell #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 33,
  parameter int unsigned Bit  = 0,
  parameter int unsigned SideW = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [NumW-1:0]  nx_i,
  input  logic [NumW-1:0]  ny_i,
  input  logic [NumW-1:0]  qx_i,
  input  logic [NumW-1:0]  qy_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [NumW-1:0]  nx_o,
  output logic [NumW-1:0]  ny_o,
  output logic [NumW-1:0]  qx_o,
  output logic [NumW-1:0]  qy_o,
  output logic [DenW-1:0]  den_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned TrialW = NumW + DenW;

  logic [TrialW-1:0] dsh, tx, ty;
  logic [NumW-1:0]   nx_d, ny_d, qx_d, qy_d;
  logic              vld_q;
  logic [NumW-1:0]   nx_q, ny_q, qx_q, qy_q;
  logic [DenW-1:0]   den_q;
  logic [SideW-1:0]  side_q;

  // compare remainder with shifted denominator and subtract
  always_comb begin
    dsh  = TrialW'(den_i) << Bit;
    tx   = TrialW'(nx_i);
    ty   = TrialW'(ny_i);
    nx_d = nx_i;
    ny_d = ny_i;
    qx_d = qx_i;
    qy_d = qy_i;
    if (tx >= dsh) begin
      nx_d      = NumW'(tx - dsh);
      qx_d[Bit] = 1'b1;
    end
    if (ty >= dsh) begin
      ny_d      = NumW'(ty - dsh);
      qy_d[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    den_q  <= den_i;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign nx_o   = nx_q;
  assign ny_o   = ny_q;
  assign qx_o   = qx_q;
  assign qy_o   = qy_q;
  assign den_o  = den_q;
  assign side_o = side_q;

endmodule

FILE: hdl/perspective_point_projector.sv
// top level: config registers, front end, divider cell chain and clip stage
//
// Perspective projector taking one point per clock cycle with no stalls.
// A point goes through two front-end stages (distance and products), then a
// chain of one division cell per quotient bit (COORD_BITS+24 cells, each cell
// working on both axes), then one clip stage that registers valid_o.
// A result appears on the result ports for exactly one cycle with valid_o high
// and cannot be held off, so the receiver must take it in that cycle. Points
// at or behind the eye or outside the screen give no result.
module perspective_point_projector #(
  parameter int unsigned COORD_BITS  = ppp_pkg::CoordBitsDef,
  parameter int unsigned SCREEN_BITS = ppp_pkg::ScreenBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         point_x_i,
  input  logic [COORD_BITS-1:0]         point_y_i,
  input  logic [COORD_BITS-1:0]         point_z_i,
  input  logic                          cfg_we_i,
  input  logic [ppp_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [ppp_pkg::CfgBits-1:0]   cfg_data_i,
  output logic                          valid_o,
  output logic [SCREEN_BITS-1:0]        screen_x_o,
  output logic [SCREEN_BITS-1:0]        screen_y_o,
  output logic [COORD_BITS-1:0]         depth_out_o
);
  import ppp_pkg::*;

  // magnitude |x|*d*256 width, denominator f width
  localparam int unsigned MagW  = COORD_BITS + DistBits + 8;
  localparam int unsigned DenW  = ((COORD_BITS > DistBits) ? COORD_BITS : DistBits) + 1;
  localparam int unsigned NumW  = MagW;
  localparam int unsigned SideW = COORD_BITS + 2 + 2 * (SCREEN_BITS + 1);
  localparam int unsigned LimW  = SCREEN_BITS + 1;

  logic [WhBits-1:0]   width_q, height_q;
  logic [DistBits-1:0] dist_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WhBits'(640);
      height_q <= WhBits'(480);
      dist_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WIDTH:  width_q  <= cfg_data_i[WhBits-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[WhBits-1:0];
        REG_DIST:   dist_q   <= cfg_data_i[DistBits-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: clamp screen size, effective distance
  logic [LimW-1:0]  w_c, h_c;
  logic [DistBits-1:0] d_c;
  logic             v1_q;
  logic [LimW-1:0]  w1_q, h1_q;
  logic [DistBits-1:0] d1_q;
  logic [COORD_BITS-1:0] x1_q, y1_q, z1_q;

  always_comb begin
    logic [LimW-1:0] lim;
    lim = LimW'(1) << SCREEN_BITS;
    w_c = (width_q  > lim) ? lim : LimW'(width_q);
    h_c = (height_q > lim) ? lim : LimW'(height_q);
    d_c = dist_q;
    if (DistBits'(w_c >> 1) > d_c) d_c = DistBits'(w_c >> 1);
    if (DistBits'(h_c >> 1) > d_c) d_c = DistBits'(h_c >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start;
  end

  always_ff @(posedge clk_i) begin
    w1_q <= w_c;
    h1_q <= h_c;
    d1_q <= d_c;
    x1_q <= point_x_i;
    y1_q <= point_y_i;
    z1_q <= point_z_i;
  end

  // stage 2: magnitudes of x*d*256 and -y*d*256, signs, f
  logic signed [DenW+1:0] f_c;
  logic [COORD_BITS:0]    ax_c, ay_c;
  logic                   nx_neg_c, ny_neg_c;
  logic                   v2_q;
  logic [NumW-1:0]        mx2_q, my2_q;
  logic [DenW-1:0]        f2_q;
  logic [SideW-1:0]       side2_q;

  always_comb begin
    f_c = $signed((DenW+2)'(d1_q)) +
          (DenW+2)'($signed(z1_q));
    nx_neg_c = x1_q[COORD_BITS-1];
    // -y is negative when y is positive and nonzero
    ny_neg_c = !y1_q[COORD_BITS-1] && (y1_q != '0);
    ax_c = x1_q[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({x1_q[COORD_BITS-1], x1_q}))
                              : (COORD_BITS+1)'(x1_q);
    ay_c = y1_q[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({y1_q[COORD_BITS-1], y1_q}))
                              : (COORD_BITS+1)'(y1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q && (f_c > 0);
  end

  always_ff @(posedge clk_i) begin
    mx2_q   <= (NumW'(ax_c) * NumW'(d1_q)) << 8;
    my2_q   <= (NumW'(ay_c) * NumW'(d1_q)) << 8;
    f2_q    <= DenW'(f_c);
    side2_q <= {z1_q, nx_neg_c, ny_neg_c, w1_q, h1_q};
  end

  // chain of division cells, most significant quotient bit first
  logic             cv   [NumW+1];
  logic [NumW-1:0]  cnx  [NumW+1];
  logic [NumW-1:0]  cny  [NumW+1];
  logic [NumW-1:0]  cqx  [NumW+1];
  logic [NumW-1:0]  cqy  [NumW+1];
  logic [DenW-1:0]  cden [NumW+1];
  logic [SideW-1:0] cside[NumW+1];

  assign cv[0]    = v2_q;
  assign cnx[0]   = mx2_q;
  assign cny[0]   = my2_q;
  assign cqx[0]   = '0;
  assign cqy[0]   = '0;
  assign cden[0]  = f2_q;
  assign cside[0] = side2_q;

  for (genvar g = 0; g < NumW; g++) begin : g_cell
    ppp_div_cell #(
      .NumW (NumW),
      .DenW (DenW),
      .Bit  (NumW - 1 - g),
      .SideW(SideW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (cv[g]),
      .nx_i  (cnx[g]),
      .ny_i  (cny[g]),
      .qx_i  (cqx[g]),
      .qy_i  (cqy[g]),
      .den_i (cden[g]),
      .side_i(cside[g]),
      .vld_o (cv[g+1]),
      .nx_o  (cnx[g+1]),
      .ny_o  (cny[g+1]),
      .qx_o  (cqx[g+1]),
      .qy_o  (cqy[g+1]),
      .den_o (cden[g+1]),
      .side_o(cside[g+1])
    );
  end

  // final stage: apply signs, add centre, truncate toward zero, clip
  localparam int unsigned SW = NumW + 2;
  logic [COORD_BITS-1:0] zf;
  logic                  sxn, syn;
  logic [LimW-1:0]       wf, hf;
  logic signed [SW-1:0]  sx_sum, sy_sum, col_c, row_c;
  logic                  keep_c;

  function automatic logic signed [SW-1:0] trunc256(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    m = v[SW-1] ? SW'(-v) : SW'(v);
    m = m >> 8;
    return v[SW-1] ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    {zf, sxn, syn, wf, hf} = cside[NumW];
    sx_sum = (sxn ? -$signed(SW'(cqx[NumW])) : $signed(SW'(cqx[NumW])))
             + $signed(SW'(wf) << 7);
    sy_sum = (syn ? -$signed(SW'(cqy[NumW])) : $signed(SW'(cqy[NumW])))
             + $signed(SW'(hf) << 7);
    col_c  = trunc256(sx_sum);
    row_c  = trunc256(sy_sum);
    keep_c = !col_c[SW-1] && !row_c[SW-1] &&
             (col_c < $signed(SW'(wf))) && (row_c < $signed(SW'(hf)));
  end

  logic vo_q;
  logic [SCREEN_BITS-1:0] sx_q, sy_q;
  logic [COORD_BITS-1:0]  dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= cv[NumW] && keep_c;
  end

  always_ff @(posedge clk_i) begin
    sx_q <= col_c[SCREEN_BITS-1:0];
    sy_q <= row_c[SCREEN_BITS-1:0];
    dz_q <= zf;
  end

  assign valid_o     = vo_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign depth_out_o = dz_q;

  // checks on the datapath
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");
  a_drop_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && (f_c <= 0)) |=> !v2_q)
    else $error("point behind eye entered divider");
  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("divider valid without front-end item");
  a_out_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> $past(cv[NumW]))
    else $error("result without item leaving chain");

endmodule
